// ===== rtl/hem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hem_pkg: shared types and constants of the HDR exposure merge
// Field widths, register indexes, reset values and inter-stage structs.
// ----------------------------------------------------------------------------
package hem_pkg;

    localparam int PIX_W         = 16;   // exposure sample, unsigned Q0.16
    localparam int GAIN_W        = 24;   // reciprocal gain, unsigned Q8.16
    localparam int OUT_W         = 24;   // merged value, unsigned Q8.16
    localparam int CNT_W         = 3;    // valid exposure count
    localparam int EXP_W         = 3;    // exposures_in_use register
    localparam int LANES         = 4;    // exposures carried per beat
    localparam int MAX_EXPOSURES = 4;
    localparam int LANE_LIMIT    = (MAX_EXPOSURES < LANES) ? MAX_EXPOSURES : LANES;

    localparam int PROD_W        = PIX_W + GAIN_W;        // Q8.32 product
    localparam int SUM_W         = PROD_W + 2;            // four products
    localparam int X_W           = SUM_W - PIX_W;         // sum in Q10.16

    // floor(x / 3) estimate: (x * RECIP) >> SHIFT, short by at most one
    localparam int DIV3_SHIFT    = 28;
    localparam int RECIP_W       = 27;
    localparam logic [RECIP_W-1:0] DIV3_RECIP = RECIP_W'((64'd1 << DIV3_SHIFT) / 3);

    localparam logic [GAIN_W-1:0] GAIN_ONE    = GAIN_W'(65536);
    localparam logic [PIX_W-1:0]  LOW_RESET   = PIX_W'(131);
    localparam logic [PIX_W-1:0]  HIGH_RESET  = PIX_W'(64881);
    localparam logic [EXP_W-1:0]  EXP_RESET   = EXP_W'(4);
    localparam logic [OUT_W-1:0]  OUT_MAX     = '1;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THRESHOLD  = 3'd0,
        REG_HIGH_THRESHOLD = 3'd1,
        REG_EXPOSURES      = 3'd2,
        REG_INV_GAIN_ONE   = 3'd3,
        REG_INV_GAIN_TWO   = 3'd4,
        REG_INV_GAIN_THREE = 3'd5
    } cfg_reg_t;

    // per-lane role for the current exposure count
    typedef struct packed {
        logic active;     // lane is within the count
        logic chk_low;    // low threshold applies
        logic chk_high;   // high threshold applies
    } lane_ctl_t;

    typedef struct packed {
        logic              ok;
        logic [PROD_W-1:0] product;
        logic [PIX_W-1:0]  raw;
    } lane_res_t;

    typedef struct packed {
        logic [X_W-1:0]   x;         // sum of products, Q10.16
        logic [CNT_W-1:0] count;
        logic [OUT_W-1:0] fallback;  // exposure 0 in Q8.16
    } merge_res_t;

endpackage
`default_nettype wire

// ===== rtl/hem_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hem_lane: one exposure lane
// Threshold check and gain multiply, registered.
// ----------------------------------------------------------------------------
module hem_lane (
    input  wire                              aclk,
    input  wire                              load,
    input  wire  [hem_pkg::PIX_W-1:0]        pixel,
    input  wire  [hem_pkg::GAIN_W-1:0]       gain,
    input  wire  [hem_pkg::PIX_W-1:0]        low_thr,
    input  wire  [hem_pkg::PIX_W-1:0]        high_thr,
    input  wire  hem_pkg::lane_ctl_t         ctl,
    output hem_pkg::lane_res_t               res_reg
);

    hem_pkg::lane_res_t res_next;

    always_comb begin
        res_next.ok      = ctl.active
                         && (!ctl.chk_low  || (pixel >= low_thr))
                         && (!ctl.chk_high || (pixel <= high_thr));
        res_next.product = hem_pkg::PROD_W'(pixel) * hem_pkg::PROD_W'(gain);
        res_next.raw     = pixel;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hem_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hem_merge: combines the lane results
// Sums valid products, counts valid lanes, keeps the exposure 0 fallback.
// ----------------------------------------------------------------------------
module hem_merge (
    input  wire                              aclk,
    input  wire                              load,
    input  wire  hem_pkg::lane_res_t         lane_res [hem_pkg::LANES],
    output hem_pkg::merge_res_t              merge_reg
);

    logic [hem_pkg::SUM_W-1:0] sum;
    logic [hem_pkg::CNT_W-1:0] count;
    hem_pkg::merge_res_t       merge_next;

    always_comb begin
        sum   = '0;
        count = '0;
        for (int i = 0; i < hem_pkg::LANES; i++) begin
            if (lane_res[i].ok) begin
                sum   = sum + hem_pkg::SUM_W'(lane_res[i].product);
                count = count + hem_pkg::CNT_W'(1);
            end
        end
        // truncating the Q10.32 sum to Q10.16 before the divide gives the same floor
        merge_next.x        = sum[hem_pkg::SUM_W-1:hem_pkg::PIX_W];
        merge_next.count    = count;
        // Q0.16 into Q8.16: same bits, zero integer part
        merge_next.fallback = hem_pkg::OUT_W'(lane_res[0].raw);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            merge_reg <= merge_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hem_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hem_div: average and saturate
// Divide by count (shift, or reciprocal multiply for three), correct, clamp.
// ----------------------------------------------------------------------------
module hem_div (
    input  wire                              aclk,
    input  wire                              load_est,
    input  wire                              load_out,
    input  wire  hem_pkg::merge_res_t        merge_res,
    output logic [hem_pkg::OUT_W-1:0]        hdr_reg,
    output logic [hem_pkg::CNT_W-1:0]        count_reg
);

    localparam int MUL_W = hem_pkg::X_W + hem_pkg::RECIP_W;

    // estimate stage
    logic [MUL_W-1:0]          prod3;
    logic [hem_pkg::X_W-1:0]   est_next;
    logic [hem_pkg::X_W-1:0]   est_reg;
    logic [hem_pkg::X_W-1:0]   x_reg;
    logic [hem_pkg::CNT_W-1:0] cnt_reg;
    logic [hem_pkg::OUT_W-1:0] fb_reg;

    always_comb begin
        prod3 = MUL_W'(merge_res.x) * MUL_W'(hem_pkg::DIV3_RECIP);
        case (merge_res.count)
            3'd2:    est_next = merge_res.x >> 1;
            3'd3:    est_next = hem_pkg::X_W'(prod3 >> hem_pkg::DIV3_SHIFT);
            3'd4:    est_next = merge_res.x >> 2;
            default: est_next = merge_res.x;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_est) begin
            est_reg <= est_next;
            x_reg   <= merge_res.x;
            cnt_reg <= merge_res.count;
            fb_reg  <= merge_res.fallback;
        end
    end

    // correction and clamp stage
    logic [hem_pkg::X_W-1:0]   rem3;
    logic [hem_pkg::X_W-1:0]   quot;
    logic [hem_pkg::OUT_W-1:0] hdr_next;

    always_comb begin
        rem3 = x_reg - ((est_reg << 1) + est_reg);
        quot = est_reg;
        if ((cnt_reg == 3'd3) && (rem3 >= hem_pkg::X_W'(3))) begin
            quot = est_reg + hem_pkg::X_W'(1);
        end
        if (cnt_reg == '0) begin
            hdr_next = fb_reg;
        end else if (quot[hem_pkg::X_W-1:hem_pkg::OUT_W] != '0) begin
            hdr_next = hem_pkg::OUT_MAX;
        end else begin
            hdr_next = quot[hem_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            hdr_reg   <= hdr_next;
            count_reg <= cnt_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hdr_exposure_merge_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted input beat passes the lane, merge, estimate and output registers to m_tdata.
// Throughput: one beat per cycle unless the output stalls; four exposure lanes run in
// parallel and the four-stage pipeline (lanes, merge, estimate, correct) holds one item each.
// Stalls start at the output register and ripple back only through full stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// hdr_exposure_merge_top: HDR merge of up to four exposures per pixel
// Per-exposure threshold check and gain scaling in lanes, then averaging of
// the valid lanes into an unsigned Q8.16 radiance with saturation.
// ----------------------------------------------------------------------------
module hdr_exposure_merge_top (
    input  wire         aclk,
    input  wire         aresetn,

    // input stream: pixel_zero, pixel_one, pixel_two, pixel_three (16 b each)
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,

    // result stream: hdr_value [23:0], valid_count [26:24], zeros above
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,

    // register writes
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [hem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [hem_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LANES = hem_pkg::LANES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [hem_pkg::PIX_W-1:0]  low_reg;
    logic [hem_pkg::PIX_W-1:0]  high_reg;
    logic [hem_pkg::EXP_W-1:0]  exp_reg;
    logic [hem_pkg::GAIN_W-1:0] gain1_reg;
    logic [hem_pkg::GAIN_W-1:0] gain2_reg;
    logic [hem_pkg::GAIN_W-1:0] gain3_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg   <= hem_pkg::LOW_RESET;
            high_reg  <= hem_pkg::HIGH_RESET;
            exp_reg   <= hem_pkg::EXP_RESET;
            gain1_reg <= hem_pkg::GAIN_ONE;
            gain2_reg <= hem_pkg::GAIN_ONE;
            gain3_reg <= hem_pkg::GAIN_ONE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (hem_pkg::cfg_reg_t'(cfg_index))
                hem_pkg::REG_LOW_THRESHOLD:  low_reg   <= cfg_data[hem_pkg::PIX_W-1:0];
                hem_pkg::REG_HIGH_THRESHOLD: high_reg  <= cfg_data[hem_pkg::PIX_W-1:0];
                hem_pkg::REG_EXPOSURES:      exp_reg   <= cfg_data[hem_pkg::EXP_W-1:0];
                hem_pkg::REG_INV_GAIN_ONE:   gain1_reg <= cfg_data[hem_pkg::GAIN_W-1:0];
                hem_pkg::REG_INV_GAIN_TWO:   gain2_reg <= cfg_data[hem_pkg::GAIN_W-1:0];
                hem_pkg::REG_INV_GAIN_THREE: gain3_reg <= cfg_data[hem_pkg::GAIN_W-1:0];
                default: ;   // unmapped index: write dropped
            endcase
        end
    end

    // Exposures in use: zero reads as one, anything above the lane limit clamps.
    logic [hem_pkg::EXP_W-1:0] n_used;

    always_comb begin
        if (exp_reg == '0) begin
            n_used = hem_pkg::EXP_W'(1);
        end else if (exp_reg > hem_pkg::EXP_W'(hem_pkg::LANE_LIMIT)) begin
            n_used = hem_pkg::EXP_W'(hem_pkg::LANE_LIMIT);
        end else begin
            n_used = exp_reg;
        end
    end

    // Lane roles: exposure 0 checks only the low threshold (also when alone),
    // the last exposure in use only the high one, those between check both.
    hem_pkg::lane_ctl_t        lane_ctl  [LANES];
    logic [hem_pkg::GAIN_W-1:0] lane_gain [LANES];

    always_comb begin
        lane_gain[0] = hem_pkg::GAIN_ONE;
        lane_gain[1] = gain1_reg;
        lane_gain[2] = gain2_reg;
        lane_gain[3] = gain3_reg;
        for (int i = 0; i < LANES; i++) begin
            lane_ctl[i].active   = hem_pkg::EXP_W'(i) < n_used;
            lane_ctl[i].chk_low  = (i == 0) || (hem_pkg::EXP_W'(i + 1) != n_used);
            lane_ctl[i].chk_high = (i != 0);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline occupancy and flow control: a stage loads when it is empty
    // or its successor loads in the same cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: exposure lanes
    // ------------------------------------------------------------------
    hem_pkg::lane_res_t lane_res [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        hem_lane u_lane (
            .aclk     (aclk),
            .load     (rdy1),
            .pixel    (s_tdata[g*hem_pkg::PIX_W +: hem_pkg::PIX_W]),
            .gain     (lane_gain[g]),
            .low_thr  (low_reg),
            .high_thr (high_reg),
            .ctl      (lane_ctl[g]),
            .res_reg  (lane_res[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 2: sum and count
    // ------------------------------------------------------------------
    hem_pkg::merge_res_t merge_res;

    hem_merge u_merge (
        .aclk      (aclk),
        .load      (rdy2),
        .lane_res  (lane_res),
        .merge_reg (merge_res)
    );

    // ------------------------------------------------------------------
    // Stages 3 and 4: divide by count, saturate, output register
    // ------------------------------------------------------------------
    logic [hem_pkg::OUT_W-1:0] hdr_value;
    logic [hem_pkg::CNT_W-1:0] valid_count;

    hem_div u_div (
        .aclk      (aclk),
        .load_est  (rdy3),
        .load_out  (rdy4),
        .merge_res (merge_res),
        .hdr_reg   (hdr_value),
        .count_reg (valid_count)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {(32 - hem_pkg::OUT_W - hem_pkg::CNT_W)'(0), valid_count, hdr_value};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // back-pressure only ever starts at a held output beat
    a_stall_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held output beat");

    // a full pipeline with a blocked output must stall the input
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready) |-> !s_tready)
        else $error("full pipeline accepted a beat");

    // never more valid exposures than lanes
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (valid_count <= hem_pkg::CNT_W'(LANES)))
        else $error("valid_count out of range");

    // fallback passes a Q0.16 sample, so the integer part is zero
    a_fallback_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (valid_count == '0)) |-> (hdr_value[hem_pkg::OUT_W-1:16] == '0))
        else $error("fallback value has an integer part");

endmodule
`default_nettype wire

// ===== tb/tb_hdr_exposure_merge_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdr_exposure_merge_top: self-checking bench for the HDR exposure merge
// Streams pixel beats through the block under a series of register settings.
// Every beat is predicted in the bench and each merged result is compared
// against it, field by field, under randomised back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_hdr_exposure_merge_top;

    // indexes beyond the register map, the block must ignore writes to them
    localparam logic [hem_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [hem_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int PHASES         = 12;
    localparam int BEATS_PER_PHASE = 130;
    localparam int TAIL_CYCLES    = 16;   // well past the pipeline latency

    typedef struct packed {
        logic [hem_pkg::OUT_W-1:0] hdr;
        logic [hem_pkg::CNT_W-1:0] cnt;
    } merged_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds a copy of the registers, predicts each accepted beat
    // and checks results in order.
    // ------------------------------------------------------------------------
    class merge_scoreboard;
        logic [hem_pkg::PIX_W-1:0]  low_thr;
        logic [hem_pkg::PIX_W-1:0]  high_thr;
        logic [hem_pkg::EXP_W-1:0]  exposures;
        logic [hem_pkg::GAIN_W-1:0] lane_gain [hem_pkg::LANES];
        merged_t                    expected_merges [$];
        int                         mismatches;
        int                         merged;
        int                         fallbacks;

        function new();
            low_thr      = hem_pkg::LOW_RESET;
            high_thr     = hem_pkg::HIGH_RESET;
            exposures    = hem_pkg::EXP_RESET;
            lane_gain[0] = hem_pkg::GAIN_ONE;
            lane_gain[1] = hem_pkg::GAIN_ONE;
            lane_gain[2] = hem_pkg::GAIN_ONE;
            lane_gain[3] = hem_pkg::GAIN_ONE;
            mismatches   = 0;
            merged       = 0;
            fallbacks    = 0;
        endfunction

        function void write_reg(logic [hem_pkg::CFG_IDX_W-1:0] idx,
                                logic [hem_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                hem_pkg::REG_LOW_THRESHOLD:  low_thr      = data[hem_pkg::PIX_W-1:0];
                hem_pkg::REG_HIGH_THRESHOLD: high_thr     = data[hem_pkg::PIX_W-1:0];
                hem_pkg::REG_EXPOSURES:      exposures    = data[hem_pkg::EXP_W-1:0];
                hem_pkg::REG_INV_GAIN_ONE:   lane_gain[1] = data[hem_pkg::GAIN_W-1:0];
                hem_pkg::REG_INV_GAIN_TWO:   lane_gain[2] = data[hem_pkg::GAIN_W-1:0];
                hem_pkg::REG_INV_GAIN_THREE: lane_gain[3] = data[hem_pkg::GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // weighted average of the usable exposures of one pixel
        function merged_t merge_pixel(logic [hem_pkg::LANES*hem_pkg::PIX_W-1:0] beat);
            int unsigned               n;
            int unsigned               cnt;
            logic [63:0]               sum;
            logic [63:0]               avg;
            logic [hem_pkg::PIX_W-1:0] v;
            logic                      ok;
            merged_t                   r;
            n = exposures;
            if (n == 0) n = 1;
            if (n > hem_pkg::LANE_LIMIT) n = hem_pkg::LANE_LIMIT;
            sum = '0;
            cnt = 0;
            for (int i = 0; i < n; i++) begin
                v = beat[i*hem_pkg::PIX_W +: hem_pkg::PIX_W];
                // first exposure: no upper bound; last one: no lower bound
                if (i == 0)
                    ok = (v >= low_thr);
                else if (i == n - 1)
                    ok = (v <= high_thr);
                else
                    ok = (v >= low_thr) && (v <= high_thr);
                if (ok) begin
                    sum += 64'(v) * 64'(lane_gain[i]);
                    cnt++;
                end
            end
            if (cnt == 0) begin
                r.hdr = hem_pkg::OUT_W'(beat[hem_pkg::PIX_W-1:0]);
                r.cnt = '0;
            end else begin
                avg   = (sum / 64'(cnt)) >> hem_pkg::PIX_W;
                r.hdr = (avg > 64'(hem_pkg::OUT_MAX)) ? hem_pkg::OUT_MAX
                                                      : avg[hem_pkg::OUT_W-1:0];
                r.cnt = hem_pkg::CNT_W'(cnt);
            end
            return r;
        endfunction

        function void note_pixel(logic [hem_pkg::LANES*hem_pkg::PIX_W-1:0] beat);
            expected_merges.insert(expected_merges.size(), merge_pixel(beat));
        endfunction

        function void check_merge(logic [31:0] data);
            merged_t want;
            if (expected_merges.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, data);
                mismatches++;
                return;
            end
            want = expected_merges.pop_front();
            merged++;
            if (want.cnt == '0) fallbacks++;
            if (data[hem_pkg::OUT_W-1:0] !== want.hdr) begin
                $display("%0t: hdr_value expected %h actual %h", $time,
                         want.hdr, data[hem_pkg::OUT_W-1:0]);
                mismatches++;
            end
            if (data[hem_pkg::OUT_W +: hem_pkg::CNT_W] !== want.cnt) begin
                $display("%0t: valid_count expected %0d actual %0d", $time,
                         want.cnt, data[hem_pkg::OUT_W +: hem_pkg::CNT_W]);
                mismatches++;
            end
            if (data[31:hem_pkg::OUT_W+hem_pkg::CNT_W] !== '0) begin
                $display("%0t: padding expected 0 actual %h", $time,
                         data[31:hem_pkg::OUT_W+hem_pkg::CNT_W]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_merges.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [63:0]                    s_tdata   = '0;   // pixel_zero..pixel_three, 16 b each
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [31:0]                    m_tdata;          // hdr_value [23:0], valid_count [26:24]
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [hem_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hem_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int src_gap_pct   = 25;   // chance the sender idles before a beat
    int sink_idle_pct = 74;   // chance the receiver is not ready in a cycle
    int settings_used = 0;

    merge_scoreboard sb = new();

    hdr_exposure_merge_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: readiness decided at the falling edge, results taken at the rising one
    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_merge(m_tdata);

    // ------------------------------------------------------------------------
    // Drivers. All of them start and finish at a falling edge.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] pack_pixels(logic [15:0] p0, logic [15:0] p1,
                                                logic [15:0] p2, logic [15:0] p3);
        return {p3, p2, p1, p0};
    endfunction

    // one register write; cfg_valid is left high so back-to-back writes stay high
    task automatic write_reg(logic [hem_pkg::CFG_IDX_W-1:0] idx,
                             logic [hem_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // s_tvalid stays high into the next beat unless a gap is drawn
    task automatic send_pixel(logic [63:0] beat);
        if ($urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(0, 99) < src_gap_pct) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel(beat);
        @(negedge aclk);
    endtask

    // stop sending and let every predicted result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // sample biased towards the thresholds and the ends of the range
    function automatic logic [15:0] pick_sample(logic [15:0] lo, logic [15:0] hi);
        int x;
        case ($urandom_range(0, 9))
            4:       x = int'(lo) + int'($urandom_range(0, 4)) - 2;
            5:       x = int'(hi) + int'($urandom_range(0, 4)) - 2;
            6:       x = 0;
            7:       x = 65535;
            8:       x = int'($urandom_range(0, lo));
            9:       x = int'($urandom_range(hi, 65535));
            default: x = int'($urandom_range(0, 65535));
        endcase
        if (x < 0) x = 0;
        if (x > 65535) x = 65535;
        return 16'(x);
    endfunction

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom);
            1:       return 24'($urandom_range(0, 24'h01FFFF));
            2:       return 24'h010000 >> $urandom_range(0, 8);
            default: return 24'($urandom_range(24'hF00000, 24'hFFFFFF));
        endcase
    endfunction

    // register set for one random phase; junk above the threshold and exposure fields
    task automatic set_phase_regs(int phase);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [2:0]  ex;
        logic [23:0] g1;
        logic [23:0] g2;
        logic [23:0] g3;
        if ($urandom_range(0, 3) == 0) begin
            lo = 16'($urandom);
            hi = 16'($urandom);
        end else begin
            lo = 16'($urandom_range(0, 8191));
            hi = 16'($urandom_range(57344, 65535));
        end
        ex = 3'($urandom_range(1, 4));
        g1 = pick_gain();
        g2 = pick_gain();
        g3 = pick_gain();
        case (phase)
            0: begin                        // everything usable, largest gains
                lo = '0; hi = '1; ex = 3'd4;
                g1 = '1; g2 = '1; g3 = '1;
            end
            1: begin                        // window closed, zero gains
                lo = '1; hi = '0; ex = 3'd4;
                g1 = '0; g2 = '0; g3 = '0;
            end
            2: ex = 3'd1;
            3: ex = 3'd2;
            4: ex = 3'd3;
            5: ex = 3'd5;                   // clipped to four
            6: ex = 3'd0;                   // read as one
            7: ex = 3'($urandom_range(6, 7));
            default: ;
        endcase
        write_reg(hem_pkg::REG_LOW_THRESHOLD,  {8'($urandom), lo});
        write_reg(hem_pkg::REG_HIGH_THRESHOLD, {8'($urandom), hi});
        write_reg(hem_pkg::REG_EXPOSURES,      {21'($urandom), ex});
        write_reg(hem_pkg::REG_INV_GAIN_ONE,   g1);
        write_reg(hem_pkg::REG_INV_GAIN_TWO,   g2);
        write_reg(hem_pkg::REG_INV_GAIN_THREE, g3);
        if (phase == 7) begin
            write_reg(REG_SPARE_A, 24'($urandom));
            write_reg(REG_SPARE_B, 24'($urandom));
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed beats at the reset register values
        send_pixel(pack_pixels(16'd0, 16'd0, 16'd0, 16'd0));
        send_pixel(pack_pixels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pack_pixels(16'd130, 16'd130, 16'd64882, 16'd64882));  // all rejected
        send_pixel(pack_pixels(16'd131, 16'd131, 16'd64881, 16'd64881));  // all on the edge
        send_pixel(pack_pixels(16'hFFFF, 16'd131, 16'd64881, 16'd0));
        send_pixel(pack_pixels(16'd0, 16'hFFFF, 16'd0, 16'hFFFF));        // fallback of zero
        send_pixel(pack_pixels(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_pixel(pack_pixels(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        drain();

        // count of zero behaves as a single exposure: only the low bound counts
        write_reg(hem_pkg::REG_EXPOSURES, 24'd0);
        cfg_valid <= 1'b0;
        send_pixel(pack_pixels(16'd130, 16'd5000, 16'd5000, 16'd5000));
        send_pixel(pack_pixels(16'hFFFF, 16'd0, 16'hFFFF, 16'd0));
        drain();

        // two exposures, open window, largest gains; upper lanes carry noise
        write_reg(hem_pkg::REG_LOW_THRESHOLD,  24'd0);
        write_reg(hem_pkg::REG_HIGH_THRESHOLD, 24'h00FFFF);
        write_reg(hem_pkg::REG_EXPOSURES,      24'd2);
        write_reg(hem_pkg::REG_INV_GAIN_ONE,   24'hFFFFFF);
        write_reg(hem_pkg::REG_INV_GAIN_TWO,   24'hFFFFFF);
        write_reg(hem_pkg::REG_INV_GAIN_THREE, 24'hFFFFFF);
        cfg_valid <= 1'b0;
        send_pixel(pack_pixels(16'hFFFF, 16'hFFFF, 16'h1234, 16'hFEDC));
        send_pixel(pack_pixels(16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        send_pixel(pack_pixels(16'd1, 16'd1, 16'd0, 16'd0));
        drain();
        settings_used += 3;

        // random phases: receiver mostly stalling, then sender mostly idle, then free run
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 4) begin
                src_gap_pct = 25; sink_idle_pct = 74;
            end else if (phase < 8) begin
                src_gap_pct = 74; sink_idle_pct = 25;
            end else begin
                src_gap_pct = 0;  sink_idle_pct = 0;
            end
            set_phase_regs(phase);
            for (int k = 0; k < BEATS_PER_PHASE; k++)
                send_pixel(pack_pixels(pick_sample(sb.low_thr, sb.high_thr),
                                       pick_sample(sb.low_thr, sb.high_thr),
                                       pick_sample(sb.low_thr, sb.high_thr),
                                       pick_sample(sb.low_thr, sb.high_thr)));
            drain();
        end

        // anything arriving late would still be flagged by the checker
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Merged %0d pixel beats over %0d register settings, %0d by fallback.",
                 sb.merged, settings_used, sb.fallbacks);
        $display("Back-pressure mixes: sender gaps, receiver stalls, and none; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
